// File: rtl/hhbf_pkg.sv
// Shared types, constants and a helper function of the HTTP Host header filter.
package hhbf_pkg;

	// Number of window cells unless the top level is given another value.
	localparam int PATTERN_MAX_DEF = 32;
	// Number of pattern bytes that the configuration registers can hold.
	localparam int PATTERN_BYTES   = 32;
	// Number of bytes in the header tag that opens the host line.
	localparam int TAG_LEN         = 6;

	localparam logic [15:0] SERVER_PORT_RST = 16'd80;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_H  = 8'h48;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_SERVER_PORT = 3'd0,
		CFG_PATTERN_LEN = 3'd1,
		CFG_PATTERN_W0  = 3'd2,
		CFG_PATTERN_W1  = 3'd3,
		CFG_PATTERN_W2  = 3'd4,
		CFG_PATTERN_W3  = 3'd5
	} cfg_index_t;

	// Scan phase of the current packet.
	typedef enum logic [2:0] {
		PH_SEEK = 3'b001,
		PH_HOST = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [31:0] queue_id;
		logic        is_tcp;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic        has_byte;
		logic [7:0]  data_byte;
		logic        last_item;
	} item_t;

	typedef struct packed {
		logic [31:0] verdict_queue_id;
		logic        drop;
	} verdict_t;

	// One host byte as it moves along the window.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} cell_link_t;

	// Shift control broadcast to every window cell.
	typedef struct packed {
		logic push1;
		logic push2;
		logic clear;
	} cell_ctl_t;

	// Byte of "Host: " at a given position.
	function automatic logic [7:0] tag_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0:    b = 8'h48;
			3'd1:    b = 8'h6f;
			3'd2:    b = 8'h73;
			3'd3:    b = 8'h74;
			3'd4:    b = 8'h3a;
			3'd5:    b = 8'h20;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/hhbf_cell.sv
// One cell of the host byte window: holds one recent host byte and compares it.
module hhbf_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hhbf_pkg::cell_ctl_t     ctl,
	input  hhbf_pkg::cell_link_t    left_q,
	input  hhbf_pkg::cell_link_t    left_w1,
	input  logic                    active,
	input  logic [7:0]              expect_byte,
	output hhbf_pkg::cell_link_t    link_q,
	output hhbf_pkg::cell_link_t    link_w1,
	output logic                    ok1,
	output logic                    ok2
);
	import hhbf_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	cell_link_t w2;

	// After the first push this cell holds its left neighbour's byte; after a
	// second push it holds what the neighbour held after the first.
	assign link_w1 = left_q;
	assign w2      = left_w1;
	assign link_q  = '{valid: valid_q, data: data_q};

	assign ok1 = !active || (link_w1.valid && (link_w1.data == expect_byte));
	assign ok2 = !active || (w2.valid && (w2.data == expect_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.push2) begin
			valid_q <= w2.valid;
		end else if (ctl.push1) begin
			valid_q <= link_w1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push2) begin
			data_q <= w2.data;
		end else if (ctl.push1) begin
			data_q <= link_w1.data;
		end
	end

endmodule

// File: rtl/http_host_block_filter_unit.sv
// Top level of the HTTP Host header filter: header scan, host window and verdict register.
//
// The filter takes one TCP payload byte per clock cycle and never pauses
// between requests: a new request is accepted in every cycle unless a verdict
// is waiting in the output register and the receiver is stalling it. Each
// request is worked in the cycle in which it is accepted, and the verdict of a
// packet is loaded into the output register in the cycle after its last
// request, so the sustained rate is one request per cycle while not stalled.
// That rate is set by the row of PATTERN_MAX window cells, which all shift
// and compare in the same cycle; a lone carriage return followed by a byte
// other than CR or LF advances the window by two places at once. The verdict
// drops a packet only when it is TCP, either port equals server_port, its
// first "Host: " line was closed by CR LF and the configured pattern occurred
// inside the host value (an empty pattern matches every complete host line).
// Configuration writes are always taken (cfg_ready is held high); a write to
// an index beyond the register list is ignored. Patterns longer than 32 bytes
// or than PATTERN_MAX never match.
module http_host_block_filter_unit #(
	parameter int PATTERN_MAX = hhbf_pkg::PATTERN_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Payload byte requests.
	input  logic               item_valid,
	output logic               item_stall,
	input  hhbf_pkg::item_t    item,
	// Verdicts, one per packet.
	output logic               verdict_valid,
	input  logic               verdict_stall,
	output hhbf_pkg::verdict_t verdict,
	// Configuration writes.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import hhbf_pkg::*;

	localparam logic [6:0] PM_W    = 7'(PATTERN_MAX);
	localparam logic [6:0] PBYTES_W = 7'(PATTERN_BYTES);

	// Configuration registers.
	logic [15:0]                         server_port_q;
	logic [5:0]                          pattern_len_q;
	logic [PATTERN_BYTES-1:0][7:0]       pattern_q;

	// Per-packet scan state.
	phase_t      phase_q,  phase_d;
	logic [2:0]  tag_cnt_q, tag_cnt_d;
	logic        cr_pend_q, cr_pend_d;
	logic        found_q,   found_d;
	logic        line_q,    line_d;
	logic        saw_q,     saw_d;

	// Output register.
	logic        verdict_valid_q;
	verdict_t    verdict_q;

	logic        take;
	logic [7:0]  b;
	logic [7:0]  first_push;
	logic        push1;
	logic        push2;
	logic        len_ok;
	logic        found1;
	logic        found2;
	logic        drop_d;
	logic [2:0]  tag_next;
	cell_ctl_t   ctl;

	cell_link_t [PATTERN_MAX-1:0] cell_q;
	cell_link_t [PATTERN_MAX-1:0] cell_w1;
	logic       [PATTERN_MAX-1:0] ok1_vec;
	logic       [PATTERN_MAX-1:0] ok2_vec;

	// A waiting verdict that the receiver stalls blocks new requests; otherwise
	// the output register frees itself in the same cycle it is read.
	assign item_stall    = verdict_valid_q && verdict_stall;
	assign take          = item_valid && !item_stall;
	assign cfg_ready     = 1'b1;
	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;
	assign b             = item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_port_q <= SERVER_PORT_RST;
			pattern_len_q <= '0;
			pattern_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SERVER_PORT: server_port_q       <= cfg_data[15:0];
				CFG_PATTERN_LEN: pattern_len_q       <= cfg_data[5:0];
				CFG_PATTERN_W0:  pattern_q[7:0]      <= cfg_data;
				CFG_PATTERN_W1:  pattern_q[15:8]     <= cfg_data;
				CFG_PATTERN_W2:  pattern_q[23:16]    <= cfg_data;
				CFG_PATTERN_W3:  pattern_q[31:24]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// A pattern can only match when it is non-empty and fits in the registers and window.
	assign len_ok = (pattern_len_q != 6'd0) && ({1'b0, pattern_len_q} <= PBYTES_W) &&
		({1'b0, pattern_len_q} <= PM_W);

	// Header tag tracking: a mismatch restarts at one when the byte is the
	// tag's first letter, else at zero.
	always_comb begin
		if (b == tag_byte(tag_cnt_q)) begin
			tag_next = tag_cnt_q + 3'd1;
		end else if (b == CHAR_H) begin
			tag_next = 3'd1;
		end else begin
			tag_next = 3'd0;
		end
	end

	// Next-state logic of the scan. In the host phase a pending carriage
	// return is resolved by the next byte: a line feed closes the line,
	// anything else makes the carriage return an ordinary host byte, pushed
	// ahead of the new one.
	always_comb begin
		phase_d    = phase_q;
		tag_cnt_d  = tag_cnt_q;
		cr_pend_d  = cr_pend_q;
		found_d    = found_q;
		line_d     = line_q;
		saw_d      = saw_q;
		push1      = 1'b0;
		push2      = 1'b0;
		first_push = cr_pend_q ? CHAR_CR : b;
		if (take && item.has_byte) begin
			saw_d = 1'b1;
			case (phase_q)
				PH_SEEK: begin
					if (tag_next == 3'(TAG_LEN)) begin
						tag_cnt_d = 3'd0;
						phase_d   = PH_HOST;
					end else begin
						tag_cnt_d = tag_next;
					end
				end
				PH_HOST: begin
					if (cr_pend_q) begin
						if (b == CHAR_LF) begin
							cr_pend_d = 1'b0;
							line_d    = 1'b1;
							phase_d   = PH_DONE;
							if (pattern_len_q == 6'd0) begin
								found_d = 1'b1;
							end
						end else begin
							push1 = 1'b1;
							if (b == CHAR_CR) begin
								cr_pend_d = 1'b1;
							end else begin
								cr_pend_d = 1'b0;
								push2     = 1'b1;
							end
						end
					end else begin
						if (b == CHAR_CR) begin
							cr_pend_d = 1'b1;
						end else begin
							push1 = 1'b1;
						end
					end
				end
				PH_DONE: ;
				default: ;
			endcase
		end
		// The pattern is tested after each byte that enters the window.
		if (len_ok && ((push1 && found1) || (push2 && found2))) begin
			found_d = 1'b1;
		end
	end

	assign drop_d = item.is_tcp &&
		((item.source_port == server_port_q) || (item.dest_port == server_port_q)) &&
		saw_d && line_d && found_d;

	assign ctl = '{push1: push1, push2: push2, clear: take && item.last_item};

	// Window cells. Cell k holds the k-th most recent host byte and compares
	// it against pattern byte (length - 1 - k) when k lies inside the pattern.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		localparam logic [6:0] K = 7'(k);
		logic       active;
		logic [6:0] pos;
		cell_link_t left_q;
		cell_link_t left_w1;

		assign active = {1'b0, pattern_len_q} > K;
		assign pos    = {1'b0, pattern_len_q} - 7'd1 - K;

		if (k == 0) begin : g_head
			assign left_q  = '{valid: 1'b1, data: first_push};
			assign left_w1 = '{valid: 1'b1, data: b};
		end else begin : g_body
			assign left_q  = cell_q[k-1];
			assign left_w1 = cell_w1[k-1];
		end

		hhbf_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_q      (left_q),
			.left_w1     (left_w1),
			.active      (active),
			.expect_byte (pattern_q[pos[4:0]]),
			.link_q      (cell_q[k]),
			.link_w1     (cell_w1[k]),
			.ok1         (ok1_vec[k]),
			.ok2         (ok2_vec[k])
		);
	end

	assign found1 = &ok1_vec;
	assign found2 = &ok2_vec;

	// Scan state: cleared after every packet's last request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEEK;
			tag_cnt_q <= 3'd0;
			cr_pend_q <= 1'b0;
			found_q   <= 1'b0;
			line_q    <= 1'b0;
			saw_q     <= 1'b0;
		end else if (take && item.last_item) begin
			phase_q   <= PH_SEEK;
			tag_cnt_q <= 3'd0;
			cr_pend_q <= 1'b0;
			found_q   <= 1'b0;
			line_q    <= 1'b0;
			saw_q     <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_d;
			tag_cnt_q <= tag_cnt_d;
			cr_pend_q <= cr_pend_d;
			found_q   <= found_d;
			line_q    <= line_d;
			saw_q     <= saw_d;
		end
	end

	// Verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (take && item.last_item) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.last_item) begin
			verdict_q <= '{verdict_queue_id: item.queue_id, drop: drop_d};
		end
	end

endmodule

// File: tb/tb_http_host_block_filter_unit.sv
// Self-checking testbench of the HTTP Host header filter: directed and random packets against a built-in predictor.
module tb_http_host_block_filter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import hhbf_pkg::*;

	// The verdict register is loaded in the cycle after the last request of a packet.
	localparam int VERDICT_LATENCY   = 1;
	// Cycles without any accepted request, verdict or write before giving up.
	localparam int QUIET_LIMIT       = 2000;
	localparam int PHASES            = 8;
	localparam int ITEMS_PER_PHASE   = 120;
	localparam int PACKETS_PER_PHASE = 8;
	localparam logic [15:0] ALT_PORT = 16'd8080;
	// First register index past the end of the list; writes there must be ignored.
	localparam logic [2:0] CFG_FIRST_UNUSED = 3'(CFG_PATTERN_W3 + 1);

	typedef logic [7:0] byte_q [$];

	// Tracks the filter's state and configuration and holds the verdicts still owed.
	class host_filter_scoreboard;
		localparam logic [8*TAG_LEN-1:0] HOST_TAG = "Host: ";

		logic [15:0] server_port;
		logic [5:0]  pattern_length;
		logic [7:0]  pattern [PATTERN_BYTES];
		phase_t      phase;
		int unsigned tag_count;
		logic [7:0]  window [PATTERN_MAX_DEF];
		int unsigned fill;
		bit          cr_pending;
		bit          found;
		bit          line_done;
		bit          saw_payload;
		verdict_t    pending_verdicts [$];
		int unsigned errors;

		function new();
			server_port    = SERVER_PORT_RST;
			pattern_length = '0;
			foreach (pattern[i]) pattern[i] = '0;
			errors = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			phase     = PH_SEEK;
			tag_count = 0;
			foreach (window[i]) window[i] = '0;
			fill        = 0;
			cr_pending  = 1'b0;
			found       = 1'b0;
			line_done   = 1'b0;
			saw_payload = 1'b0;
		endfunction

		function logic [7:0] tag_at(int unsigned pos);
			return HOST_TAG[8*(TAG_LEN-1-pos) +: 8];
		endfunction

		function void set_register(logic [2:0] idx, logic [63:0] data);
			case (idx)
				CFG_SERVER_PORT: server_port = data[15:0];
				CFG_PATTERN_LEN: pattern_length = data[5:0];
				CFG_PATTERN_W0, CFG_PATTERN_W1, CFG_PATTERN_W2, CFG_PATTERN_W3: begin
					for (int k = 0; k < 8; k++)
						pattern[(idx - CFG_PATTERN_W0) * 8 + k] = data[8*k +: 8];
				end
				default: ;
			endcase
		endfunction

		// Moves one host byte into the window and compares the tail with the pattern.
		function void shift_in_host(logic [7:0] b);
			int unsigned len;
			bit hit;
			len = pattern_length;
			for (int i = 0; i < PATTERN_MAX_DEF - 1; i++) window[i] = window[i+1];
			window[PATTERN_MAX_DEF-1] = b;
			if (fill < PATTERN_MAX_DEF) fill++;
			if (len == 0 || len > PATTERN_BYTES || len > PATTERN_MAX_DEF || fill < len) return;
			hit = 1'b1;
			for (int i = 0; i < len; i++)
				if (window[PATTERN_MAX_DEF-len+i] !== pattern[i]) hit = 1'b0;
			if (hit) found = 1'b1;
		endfunction

		function void take_byte(logic [7:0] b);
			saw_payload = 1'b1;
			case (phase)
				PH_SEEK: begin
					if (b == tag_at(tag_count)) tag_count++;
					else tag_count = (b == tag_at(0)) ? 1 : 0;
					if (tag_count >= TAG_LEN) begin
						tag_count = 0;
						phase     = PH_HOST;
					end
				end
				PH_HOST: begin
					if (cr_pending) begin
						if (b == CHAR_LF) begin
							cr_pending = 1'b0;
							line_done  = 1'b1;
							phase      = PH_DONE;
							if (pattern_length == 0) found = 1'b1;
							return;
						end
						shift_in_host(CHAR_CR);
						cr_pending = 1'b0;
					end
					if (b == CHAR_CR) cr_pending = 1'b1;
					else shift_in_host(b);
				end
				default: ;
			endcase
		endfunction

		function void note_request(item_t r);
			verdict_t v;
			if (r.has_byte) take_byte(r.data_byte);
			if (!r.last_item) return;
			v.verdict_queue_id = r.queue_id;
			v.drop = r.is_tcp && (r.source_port == server_port || r.dest_port == server_port)
				&& saw_payload && line_done && found;
			pending_verdicts.push_back(v);
			clear_packet();
		endfunction

		task report(string what);
			$display("MISMATCH at %0t ns: %s", $time, what);
			errors++;
		endtask

		task check_verdict(verdict_t got);
			verdict_t want;
			if (pending_verdicts.size() == 0) begin
				report($sformatf("verdict for packet %h with none owed", got.verdict_queue_id));
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.verdict_queue_id !== want.verdict_queue_id)
				report($sformatf("packet id %h, wanted %h", got.verdict_queue_id,
					want.verdict_queue_id));
			if (got.drop !== want.drop)
				report($sformatf("packet %h drop %b, wanted %b", want.verdict_queue_id,
					got.drop, want.drop));
		endtask

		task close();
			if (pending_verdicts.size() != 0)
				report($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        verdict_valid;
	logic        verdict_stall;
	verdict_t    verdict;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	host_filter_scoreboard sb;
	// When set, neither side inserts idle cycles, so requests run back to back.
	bit          no_idle;
	int unsigned items_sent;
	int unsigned quiet_cycles;
	bit          moved;

	http_host_block_filter_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Number of idle cycles a side inserts before its next request or verdict.
	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 12);
	endfunction

	// Everything is sampled on the rising edge, where the stimulus driven on the
	// falling edge has long settled. Verdicts are checked before the request of
	// the same edge is noted, although a verdict can never belong to a request
	// accepted on the same edge. The watchdog lives here as well, since this is
	// the one place that sees every handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (verdict_valid && !verdict_stall) begin
				sb.check_verdict(verdict);
				moved = 1'b1;
			end
			if (item_valid && !item_stall) begin
				sb.note_request(item);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				sb.set_register(cfg_index, cfg_data);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// The verdict receiver stalls for a random number of cycles ahead of each
	// verdict, then holds stall low until a verdict has been taken.
	initial begin
		int n;
		verdict_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = draw_wait();
			if (n > 0) begin
				verdict_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			verdict_stall <= 1'b0;
			do @(posedge clk); while (!verdict_valid);
			@(negedge clk);
		end
	end

	// Presents one request and holds it until the filter takes it. Called and
	// left on a falling edge; valid is only lowered when a gap follows, so it is
	// never lowered and raised again within one time step.
	task automatic send_request(input item_t r);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= r;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	// Sends one packet as a series of byte requests. With noise on, requests
	// without a byte are slipped in and the TCP flag and ports of non-final
	// requests are sometimes scrambled, as only the final request counts.
	task automatic send_packet(input item_t head, input byte_q payload, input bit empty_tail,
			input bit noisy);
		item_t r;
		for (int i = 0; i < payload.size(); i++) begin
			if (noisy && $urandom_range(0, 9) == 0) begin
				r           = head;
				r.has_byte  = 1'b0;
				r.data_byte = 8'($urandom_range(0, 255));
				r.last_item = 1'b0;
				send_request(r);
				items_sent++;
			end
			r           = head;
			r.has_byte  = 1'b1;
			r.data_byte = payload[i];
			r.last_item = (i == payload.size() - 1) && !empty_tail;
			if (noisy && !r.last_item && $urandom_range(0, 7) == 0) begin
				r.is_tcp      = 1'($urandom_range(0, 1));
				r.source_port = 16'($urandom);
				r.dest_port   = 16'($urandom);
			end
			send_request(r);
			items_sent++;
		end
		if (empty_tail || payload.size() == 0) begin
			r           = head;
			r.has_byte  = 1'b0;
			r.data_byte = 8'($urandom_range(0, 255));
			r.last_item = 1'b1;
			send_request(r);
			items_sent++;
		end
	endtask

	// Writes one register; called and left on a falling edge with valid still high.
	task automatic write_register(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Waits until every owed verdict has arrived and the pipeline has emptied.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0) @(negedge clk);
		repeat (VERDICT_LATENCY + 3) @(negedge clk);
	endtask

	function automatic byte_q add_text(input byte_q q, input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	// A byte of a host name: mostly lower-case letters, now and then a dot, a
	// lone carriage return or an arbitrary byte.
	function automatic logic [7:0] host_byte();
		logic [7:0] b;
		case ($urandom_range(0, 15))
			0:       b = CHAR_CR;
			1:       b = 8'($urandom_range(0, 255));
			2:       b = ".";
			default: b = 8'h61 + 8'($urandom_range(0, 25));
		endcase
		return b;
	endfunction

	// Packet header: identifiers at both extremes now and then, and ports that
	// mostly hit the server port on one side, the other or both.
	function automatic item_t make_head();
		item_t r;
		r = '0;
		case ($urandom_range(0, 5))
			0:       r.queue_id = '0;
			1:       r.queue_id = '1;
			default: r.queue_id = $urandom;
		endcase
		r.is_tcp      = ($urandom_range(0, 7) != 0);
		r.source_port = 16'($urandom);
		r.dest_port   = 16'($urandom);
		case ($urandom_range(0, 4))
			0, 1: r.dest_port = sb.server_port;
			2:    r.source_port = sb.server_port;
			3: begin
				r.source_port = sb.server_port;
				r.dest_port   = sb.server_port;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Most payloads are well-formed host lines carrying the current pattern,
	// sometimes with one bit flipped; the rest are noise, empty payloads, a
	// malformed header tag or a host line that is never closed.
	function automatic byte_q build_payload();
		byte_q      q;
		int         kind;
		int         plen;
		int         flip_at;
		logic [7:0] b;
		string      tag_chars;
		tag_chars = "Host: ";
		kind = $urandom_range(0, 9);
		if (kind == 7) return q;
		if (kind == 6) begin
			repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
			return q;
		end
		repeat ($urandom_range(0, 4))
			q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
				: tag_chars[$urandom_range(0, TAG_LEN - 1)]);
		if ($urandom_range(0, 3) == 0) q = add_text(q, "Hos");
		if (kind == 8) q = add_text(q, "Host:");
		else q = add_text(q, "Host: ");
		repeat ($urandom_range(0, 4)) q.push_back(host_byte());
		plen = (sb.pattern_length > PATTERN_BYTES) ? PATTERN_BYTES : sb.pattern_length;
		if ($urandom_range(0, 2) != 0) begin
			flip_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, plen) : plen;
			for (int i = 0; i < plen; i++) begin
				b = sb.pattern[i];
				if (i == flip_at) b ^= 8'(1 << $urandom_range(0, 7));
				q.push_back(b);
			end
		end
		repeat ($urandom_range(0, 4)) q.push_back(host_byte());
		if (kind == 5) begin
			case ($urandom_range(0, 2))
				0: ;
				1: q.push_back(CHAR_CR);
				default: begin
					q.push_back(CHAR_CR);
					q.push_back("x");
				end
			endcase
		end else begin
			q.push_back(CHAR_CR);
			q.push_back(CHAR_LF);
		end
		repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 5) == 0) q = add_text(q, "Host: ");
		return q;
	endfunction

	// Writes every register for one phase. The settings cover the empty
	// pattern, one byte, the full 32 bytes and oversized lengths, with ports at
	// both ends of their range; upper data bits beyond each register are junk.
	task automatic configure_phase(input int p);
		logic [15:0] port;
		logic [5:0]  len;
		logic [63:0] w;
		bit          letters;
		letters = p[0];
		port    = 16'($urandom);
		len     = 6'($urandom_range(1, 32));
		case (p)
			0: begin
				port = SERVER_PORT_RST;
				len  = '0;
			end
			1: begin
				port = '0;
				len  = 6'd1;
			end
			2: begin
				port = '1;
				len  = 6'd32;
			end
			3: len = 6'd63;
			4: begin
				port = SERVER_PORT_RST;
				len  = 6'($urandom_range(2, 12));
			end
			5: len = 6'd33;
			6: port = SERVER_PORT_RST;
			default: begin
				port = ALT_PORT;
				len  = 6'($urandom_range(1, 6));
			end
		endcase
		w = {$urandom, $urandom};
		w[15:0] = port;
		write_register(CFG_SERVER_PORT, w);
		w = {$urandom, $urandom};
		w[5:0] = len;
		write_register(CFG_PATTERN_LEN, w);
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 8; j++)
				w[8*j +: 8] = letters ? host_byte() : 8'($urandom_range(0, 255));
			write_register(3'(CFG_PATTERN_W0 + k), w);
		end
		if ($urandom_range(0, 1) == 1)
			write_register(3'(CFG_FIRST_UNUSED + $urandom_range(0, 1)), {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		item_t       head;
		byte_q       q;
		byte_q       none;
		int unsigned phase_start;
		int unsigned phase_packets;
		sb           = new();
		item_valid   = 1'b0;
		item         = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		no_idle      = 1'b0;
		items_sent   = 0;
		quiet_cycles = 0;
		arst_n       = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, first with the reset settings: an empty host value
		// closed at once must drop, as the empty pattern matches any complete
		// line, and an empty non-TCP payload must be accepted.
		head             = '0;
		head.is_tcp      = 1'b1;
		head.source_port = '1;
		head.dest_port   = SERVER_PORT_RST;
		q = add_text(none, "Host: ");
		q.push_back(CHAR_CR);
		q.push_back(CHAR_LF);
		send_packet(head, q, 1'b0, 1'b0);
		head.queue_id    = '1;
		head.is_tcp      = 1'b0;
		head.source_port = SERVER_PORT_RST;
		head.dest_port   = '0;
		send_packet(head, none, 1'b1, 1'b0);

		// A one-byte pattern that is a carriage return: a lone CR inside the host
		// value counts as a host byte and must match, and the byte after the
		// closing CR LF must be ignored.
		wait_idle();
		write_register(CFG_PATTERN_LEN, 64'd1);
		write_register(CFG_PATTERN_W0, {56'd0, CHAR_CR});
		cfg_valid <= 1'b0;
		head.queue_id    = $urandom;
		head.is_tcp      = 1'b1;
		head.dest_port   = 16'($urandom);
		q = add_text(none, "Host: x");
		q.push_back(CHAR_CR);
		q.push_back("y");
		q.push_back(CHAR_CR);
		q.push_back(CHAR_LF);
		q.push_back("Z");
		send_packet(head, q, 1'b1, 1'b0);

		// Random part, one setting per phase, written only once the filter is idle.
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			configure_phase(p);
			phase_start   = items_sent;
			phase_packets = 0;
			while (items_sent - phase_start < ITEMS_PER_PHASE
					|| phase_packets < PACKETS_PER_PHASE) begin
				no_idle = ($urandom_range(0, 4) == 0);
				send_packet(make_head(), build_payload(), ($urandom_range(0, 2) == 0), 1'b1);
				phase_packets++;
			end
		end

		no_idle = 1'b0;
		wait_idle();
		sb.close();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
